// ===== rtl/core/i2cbb_pkg.sv =====
// Package: word types, microcode control word and microcode table for the I2C write master.
`timescale 1ns / 1ps

package i2cbb_pkg;

    localparam int BITS_PER_BYTE = 8;
    localparam int CNT_W         = $clog2(BITS_PER_BYTE);
    localparam int UPC_W         = 4;

    // command codes
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_STOP  = 2'd2;

    // microcode entry points
    localparam logic [UPC_W-1:0] UA_START = 4'd0;
    localparam logic [UPC_W-1:0] UA_WRITE = 4'd3;
    localparam logic [UPC_W-1:0] UA_BIT   = 4'd4;
    localparam logic [UPC_W-1:0] UA_STOP  = 4'd10;

    // register indexes on the config port
    localparam logic REG_BRIEF = 1'b0;
    localparam logic REG_LONG  = 1'b1;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] tx_byte;
        logic       sensed_sda;
    } in_word_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       scl_drive;
        logic       sda_drive;
        logic       hold_long;
        logic [1:0] hold_units;
        logic       ack_seen;
        logic       ack_valid;
        logic       last;
    } out_word_t;

    typedef enum logic [1:0] {
        PIN_KEEP,
        PIN_LO,
        PIN_HI,
        PIN_MSB
    } pin_op_t;

    typedef enum logic [1:0] {
        DIR_KEEP,
        DIR_REL,
        DIR_DRV
    } dir_op_t;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } seq_state_t;

    typedef struct packed {
        pin_op_t    scl_op;
        pin_op_t    sda_op;
        dir_op_t    scl_dir_op;
        dir_op_t    sda_dir_op;
        logic       shift_en;
        logic       cnt_load;
        logic       loop;
        logic       hold_long;
        logic [1:0] units;
        logic       ack;
        logic       last;
    } ucw_t;

    typedef struct packed {
        logic step;
        ucw_t cw;
    } seq_ctl_t;

    function automatic ucw_t uw(pin_op_t scl, pin_op_t sda, dir_op_t scld, dir_op_t sdad,
                                logic sh, logic ld, logic lp, logic lng, logic [1:0] u,
                                logic ack, logic lst);
        ucw_t w;
        w.scl_op     = scl;
        w.sda_op     = sda;
        w.scl_dir_op = scld;
        w.sda_dir_op = sdad;
        w.shift_en   = sh;
        w.cnt_load   = ld;
        w.loop       = lp;
        w.hold_long  = lng;
        w.units      = u;
        w.ack        = ack;
        w.last       = lst;
        return w;
    endfunction

    // One word per phase; every word emits one output word.
    function automatic ucw_t ucode_rom(logic [UPC_W-1:0] addr);
        ucw_t w;
        case (addr)
            // start: both high and driven, SDA low, SCL low held twice
            4'd0:    w = uw(PIN_HI,   PIN_HI,   DIR_DRV,  DIR_DRV,  1'b0, 1'b0, 1'b0,
                            1'b1, 2'd1, 1'b0, 1'b0);
            4'd1:    w = uw(PIN_KEEP, PIN_LO,   DIR_KEEP, DIR_KEEP, 1'b0, 1'b0, 1'b0,
                            1'b1, 2'd1, 1'b0, 1'b0);
            4'd2:    w = uw(PIN_LO,   PIN_KEEP, DIR_KEEP, DIR_KEEP, 1'b0, 1'b0, 1'b0,
                            1'b1, 2'd2, 1'b0, 1'b1);
            // write: take both lines, then the bit loop
            4'd3:    w = uw(PIN_KEEP, PIN_KEEP, DIR_DRV,  DIR_DRV,  1'b0, 1'b1, 1'b0,
                            1'b0, 2'd1, 1'b0, 1'b0);
            4'd4:    w = uw(PIN_KEEP, PIN_MSB,  DIR_KEEP, DIR_KEEP, 1'b1, 1'b0, 1'b0,
                            1'b0, 2'd1, 1'b0, 1'b0);
            4'd5:    w = uw(PIN_HI,   PIN_KEEP, DIR_KEEP, DIR_KEEP, 1'b0, 1'b0, 1'b0,
                            1'b0, 2'd1, 1'b0, 1'b0);
            4'd6:    w = uw(PIN_LO,   PIN_KEEP, DIR_KEEP, DIR_KEEP, 1'b0, 1'b0, 1'b1,
                            1'b0, 2'd1, 1'b0, 1'b0);
            // ack clock: release SDA, long SCL high, retake SDA and sample
            4'd7:    w = uw(PIN_KEEP, PIN_HI,   DIR_KEEP, DIR_REL,  1'b0, 1'b0, 1'b0,
                            1'b0, 2'd1, 1'b0, 1'b0);
            4'd8:    w = uw(PIN_HI,   PIN_KEEP, DIR_KEEP, DIR_KEEP, 1'b0, 1'b0, 1'b0,
                            1'b0, 2'd2, 1'b0, 1'b0);
            4'd9:    w = uw(PIN_LO,   PIN_KEEP, DIR_KEEP, DIR_DRV,  1'b0, 1'b0, 1'b0,
                            1'b0, 2'd1, 1'b1, 1'b1);
            // stop: SDA low, SCL high, SDA high
            4'd10:   w = uw(PIN_KEEP, PIN_LO,   DIR_KEEP, DIR_DRV,  1'b0, 1'b0, 1'b0,
                            1'b1, 2'd1, 1'b0, 1'b0);
            4'd11:   w = uw(PIN_HI,   PIN_KEEP, DIR_KEEP, DIR_KEEP, 1'b0, 1'b0, 1'b0,
                            1'b1, 2'd1, 1'b0, 1'b0);
            4'd12:   w = uw(PIN_KEEP, PIN_HI,   DIR_KEEP, DIR_KEEP, 1'b0, 1'b0, 1'b0,
                            1'b1, 2'd1, 1'b0, 1'b1);
            default: w = uw(PIN_KEEP, PIN_KEEP, DIR_KEEP, DIR_KEEP, 1'b0, 1'b0, 1'b0,
                            1'b0, 2'd1, 1'b0, 1'b1);
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/core/i2cbb_seq.sv =====
// Microcode sequencer: step counter, bit loop counter and conditional jump.
`timescale 1ns / 1ps

module i2cbb_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [1:0]           cmd,
    input  logic                 adv,
    output logic                 idle,
    output i2cbb_pkg::seq_ctl_t  ctl
);

    i2cbb_pkg::seq_state_t            state_reg, state_next;
    logic [i2cbb_pkg::UPC_W-1:0]      pc_reg, pc_next;
    logic [i2cbb_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    i2cbb_pkg::ucw_t                  cw;

    assign cw = i2cbb_pkg::ucode_rom(pc_reg);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg <= i2cbb_pkg::SEQ_IDLE;
            pc_reg    <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        pc_next    = pc_reg;
        cnt_next   = cnt_reg;
        ctl.step   = 1'b0;
        ctl.cw     = cw;
        idle       = 1'b0;
        case (state_reg)
            i2cbb_pkg::SEQ_IDLE:
            begin
                idle = 1'b1;
                if (start)
                begin
                    // unused code is taken and dropped
                    case (cmd)
                        i2cbb_pkg::CMD_START:
                        begin
                            pc_next    = i2cbb_pkg::UA_START;
                            state_next = i2cbb_pkg::SEQ_RUN;
                        end
                        i2cbb_pkg::CMD_WRITE:
                        begin
                            pc_next    = i2cbb_pkg::UA_WRITE;
                            state_next = i2cbb_pkg::SEQ_RUN;
                        end
                        i2cbb_pkg::CMD_STOP:
                        begin
                            pc_next    = i2cbb_pkg::UA_STOP;
                            state_next = i2cbb_pkg::SEQ_RUN;
                        end
                        default: ;
                    endcase
                end
            end
            i2cbb_pkg::SEQ_RUN:
            begin
                ctl.step = adv;
                if (adv)
                begin
                    if (cw.cnt_load)
                        cnt_next = i2cbb_pkg::CNT_W'(i2cbb_pkg::BITS_PER_BYTE - 1);
                    if (cw.last)
                        state_next = i2cbb_pkg::SEQ_IDLE;
                    else if (cw.loop && cnt_reg != '0)
                    begin
                        pc_next  = i2cbb_pkg::UA_BIT;
                        cnt_next = cnt_reg - 1'b1;
                    end
                    else
                        pc_next = pc_reg + 1'b1;
                end
            end
            default: state_next = i2cbb_pkg::SEQ_IDLE;
        endcase
    end

endmodule

// ===== rtl/core/i2cbb_dp.sv =====
// Datapath: pin latches, drive enables, shift register and output word register.
`timescale 1ns / 1ps

module i2cbb_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  i2cbb_pkg::in_word_t   in_word,
    input  i2cbb_pkg::seq_ctl_t   ctl,
    input  logic                  out_ready,
    output logic                  out_valid,
    output i2cbb_pkg::out_word_t  out_word
);

    logic                  scl_reg, scl_next;
    logic                  sda_reg, sda_next;
    logic                  scl_dir_reg, scl_dir_next;
    logic                  sda_dir_reg, sda_dir_next;
    logic [7:0]            shift_reg;
    logic                  sensed_reg;
    logic                  out_valid_reg;
    i2cbb_pkg::out_word_t  out_word_reg;

    always_comb begin
        case (ctl.cw.scl_op)
            i2cbb_pkg::PIN_LO: scl_next = 1'b0;
            i2cbb_pkg::PIN_HI: scl_next = 1'b1;
            default:           scl_next = scl_reg;
        endcase
        case (ctl.cw.sda_op)
            i2cbb_pkg::PIN_LO:  sda_next = 1'b0;
            i2cbb_pkg::PIN_HI:  sda_next = 1'b1;
            i2cbb_pkg::PIN_MSB: sda_next = shift_reg[7];
            default:            sda_next = sda_reg;
        endcase
        case (ctl.cw.scl_dir_op)
            i2cbb_pkg::DIR_REL: scl_dir_next = 1'b0;
            i2cbb_pkg::DIR_DRV: scl_dir_next = 1'b1;
            default:            scl_dir_next = scl_dir_reg;
        endcase
        case (ctl.cw.sda_dir_op)
            i2cbb_pkg::DIR_REL: sda_dir_next = 1'b0;
            i2cbb_pkg::DIR_DRV: sda_dir_next = 1'b1;
            default:            sda_dir_next = sda_dir_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            scl_dir_reg   <= 1'b0;
            sda_dir_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.step)
            begin
                scl_reg       <= scl_next;
                sda_reg       <= sda_next;
                scl_dir_reg   <= scl_dir_next;
                sda_dir_reg   <= sda_dir_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload: no reset
    always_ff @(posedge clk) begin
        if (load)
        begin
            shift_reg  <= in_word.tx_byte;
            sensed_reg <= in_word.sensed_sda;
        end
        else if (ctl.step && ctl.cw.shift_en)
            shift_reg <= {shift_reg[6:0], 1'b0};
        if (ctl.step)
        begin
            out_word_reg.scl_level  <= scl_next;
            out_word_reg.sda_level  <= sda_next;
            out_word_reg.scl_drive  <= scl_dir_next;
            out_word_reg.sda_drive  <= sda_dir_next;
            out_word_reg.hold_long  <= ctl.cw.hold_long;
            out_word_reg.hold_units <= ctl.cw.units;
            out_word_reg.ack_seen   <= ctl.cw.ack & ~sensed_reg;
            out_word_reg.ack_valid  <= ctl.cw.ack;
            out_word_reg.last       <= ctl.cw.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

// ===== rtl/core/i2c_bitbang_master_write_top.sv =====
// Top level: write-only I2C bit-bang master with APB timing registers.
// The sequencer enters its run state on an accepted command word; its first step then loads the output register.
// Throughput: one phase word per cycle while the output register is not stalled,
//   set by the microcode step counter that runs one control word per phase.
// Output register stalls the sequencer when the consumer holds out_ready low.
// Reset (rst_n, async low): SCL/SDA latches high, both lines released, sequencer idle,
//   brief_ticks and long_ticks zero.
`timescale 1ns / 1ps

module i2c_bitbang_master_write_top (
    input  logic                  clk,
    input  logic                  rst_n,
    // command words
    input  logic                  in_valid,
    output logic                  in_ready,
    input  i2cbb_pkg::in_word_t   in_word,
    // phase words
    output logic                  out_valid,
    input  logic                  out_ready,
    output i2cbb_pkg::out_word_t  out_word,
    // APB config port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic                 in_acc;
    logic                 adv;
    logic                 idle;
    i2cbb_pkg::seq_ctl_t  ctl;
    logic [15:0]          brief_ticks_reg;
    logic [15:0]          long_ticks_reg;

    // Timing registers are held for the pin driver that consumes the phase words;
    // a phase lasts (hold_long ? long : brief) * hold_units ticks there.
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            brief_ticks_reg <= '0;
            long_ticks_reg  <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[2])
                i2cbb_pkg::REG_BRIEF: brief_ticks_reg <= pwdata[15:0];
                i2cbb_pkg::REG_LONG:  long_ticks_reg  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            i2cbb_pkg::REG_BRIEF: prdata = {16'd0, brief_ticks_reg};
            i2cbb_pkg::REG_LONG:  prdata = {16'd0, long_ticks_reg};
            default:              prdata = '0;
        endcase
    end

    // Commands are taken only while the sequencer is idle; the last phase word of
    // the previous command may still sit in the output register.
    assign in_ready = idle;
    assign in_acc   = in_valid && in_ready;

    // sequencer steps whenever the output register is empty or being drained
    assign adv = !out_valid || out_ready;

    i2cbb_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (in_acc),
        .cmd   (in_word.cmd),
        .adv   (adv),
        .idle  (idle),
        .ctl   (ctl)
    );

    i2cbb_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (in_acc),
        .in_word   (in_word),
        .ctl       (ctl),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_word  (out_word)
    );

endmodule

// ===== rtl/core/i2cbb_checker.sv =====
// Port-level checker for the I2C write master, bound to the top level.
`timescale 1ns / 1ps

module i2cbb_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input i2cbb_pkg::in_word_t   in_word,
    input logic                  out_valid,
    input logic                  out_ready,
    input i2cbb_pkg::out_word_t  out_word
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_word))
        else $error("stalled phase word changed");

    a_ack_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.ack_valid |-> out_word.last)
        else $error("ack reported before last phase");

    a_ack_seen_qual: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_word.ack_valid |-> !out_word.ack_seen)
        else $error("ack_seen without ack_valid");

    a_units: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_word.hold_units == 2'd1 || out_word.hold_units == 2'd2))
        else $error("hold_units out of range");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready &&
        (in_word.cmd == i2cbb_pkg::CMD_START || in_word.cmd == i2cbb_pkg::CMD_WRITE ||
         in_word.cmd == i2cbb_pkg::CMD_STOP) |=> !in_ready)
        else $error("new command taken while sequencing");

endmodule

bind i2c_bitbang_master_write_top i2cbb_checker u_i2cbb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
);

// ===== tb/i2c_phase_checker.sv =====
// Checker: predicts the pin phase words of each command word and compares them with the DUT.
`timescale 1ns / 1ps

module i2c_phase_checker
    import i2cbb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  in_word_t    in_word,
    input  logic        out_valid,
    input  logic        out_ready,
    input  out_word_t   out_word,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    output int          errors,
    output int          pending
);

    // mirrored pin state
    logic        scl_lat;
    logic        sda_lat;
    logic        scl_en;
    logic        sda_en;
    logic [7:0]  tx_shift;
    logic [15:0] brief_cfg;
    logic [15:0] long_cfg;

    out_word_t   phase_q[$];
    out_word_t   want;
    logic [31:0] rd_want;

    task automatic add_phase(input logic lng, input logic [1:0] units, input logic ack,
                             input logic ack_vld, input logic lst);
        out_word_t p;
        p.scl_level  = scl_lat;
        p.sda_level  = sda_lat;
        p.scl_drive  = scl_en;
        p.sda_drive  = sda_en;
        p.hold_long  = lng;
        p.hold_units = units;
        p.ack_seen   = ack;
        p.ack_valid  = ack_vld;
        p.last       = lst;
        phase_q.push_back(p);
    endtask

    // pin phases one command word causes; unknown codes cause none
    task automatic predict_phases(input in_word_t w);
        int i;
        case (w.cmd)
            CMD_START:
            begin
                scl_lat = 1'b1;
                sda_lat = 1'b1;
                scl_en  = 1'b1;
                sda_en  = 1'b1;
                add_phase(1'b1, 2'd1, 1'b0, 1'b0, 1'b0);
                sda_lat = 1'b0;
                add_phase(1'b1, 2'd1, 1'b0, 1'b0, 1'b0);
                scl_lat = 1'b0;
                add_phase(1'b1, 2'd2, 1'b0, 1'b0, 1'b1);
            end
            CMD_WRITE:
            begin
                tx_shift = w.tx_byte;
                scl_en   = 1'b1;
                sda_en   = 1'b1;
                add_phase(1'b0, 2'd1, 1'b0, 1'b0, 1'b0);
                for (i = 0; i < BITS_PER_BYTE; i++)
                begin
                    sda_lat = tx_shift[7];
                    add_phase(1'b0, 2'd1, 1'b0, 1'b0, 1'b0);
                    tx_shift = {tx_shift[6:0], 1'b0};
                    scl_lat  = 1'b1;
                    add_phase(1'b0, 2'd1, 1'b0, 1'b0, 1'b0);
                    scl_lat  = 1'b0;
                    add_phase(1'b0, 2'd1, 1'b0, 1'b0, 1'b0);
                end
                // ack clock: SDA released, long high, then retaken
                sda_en  = 1'b0;
                sda_lat = 1'b1;
                add_phase(1'b0, 2'd1, 1'b0, 1'b0, 1'b0);
                scl_lat = 1'b1;
                add_phase(1'b0, 2'd2, 1'b0, 1'b0, 1'b0);
                sda_en  = 1'b1;
                scl_lat = 1'b0;
                add_phase(1'b0, 2'd1, ~w.sensed_sda, 1'b1, 1'b1);
            end
            CMD_STOP:
            begin
                // SCL drive left alone here
                sda_en  = 1'b1;
                sda_lat = 1'b0;
                add_phase(1'b1, 2'd1, 1'b0, 1'b0, 1'b0);
                scl_lat = 1'b1;
                add_phase(1'b1, 2'd1, 1'b0, 1'b0, 1'b0);
                sda_lat = 1'b1;
                add_phase(1'b1, 2'd1, 1'b0, 1'b0, 1'b1);
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [1:0] exp_v,
                               input logic [1:0] got_v);
        if (got_v !== exp_v)
        begin
            $display("%0t: phase %s mismatch: expected %0d, actual %0d",
                     $time, name, exp_v, got_v);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scl_lat   = 1'b1;
            sda_lat   = 1'b1;
            scl_en    = 1'b0;
            sda_en    = 1'b0;
            tx_shift  = 8'h00;
            brief_cfg = 16'h0000;
            long_cfg  = 16'h0000;
            errors    = 0;
            phase_q.delete();
            pending <= 0;
        end
        else
        begin
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    if (paddr[2] == REG_LONG)
                        long_cfg = pwdata[15:0];
                    else
                        brief_cfg = pwdata[15:0];
                end
                else
                begin
                    rd_want = (paddr[2] == REG_LONG) ? {16'h0, long_cfg} : {16'h0, brief_cfg};
                    if (prdata !== rd_want)
                    begin
                        $display("%0t: register read at %0d: expected %h, actual %h",
                                 $time, paddr, rd_want, prdata);
                        errors++;
                    end
                end
            end

            if (in_valid && in_ready)
                predict_phases(in_word);

            if (out_valid && out_ready)
            begin
                if (phase_q.size() == 0)
                begin
                    $display("%0t: unexpected phase word: expected none, actual %h",
                             $time, out_word);
                    errors++;
                end
                else
                begin
                    want = phase_q.pop_front();
                    check_field("scl_level",  2'(want.scl_level),  2'(out_word.scl_level));
                    check_field("sda_level",  2'(want.sda_level),  2'(out_word.sda_level));
                    check_field("scl_drive",  2'(want.scl_drive),  2'(out_word.scl_drive));
                    check_field("sda_drive",  2'(want.sda_drive),  2'(out_word.sda_drive));
                    check_field("hold_long",  2'(want.hold_long),  2'(out_word.hold_long));
                    check_field("hold_units", want.hold_units,     out_word.hold_units);
                    check_field("ack_seen",   2'(want.ack_seen),   2'(out_word.ack_seen));
                    check_field("ack_valid",  2'(want.ack_valid),  2'(out_word.ack_valid));
                    check_field("last",       2'(want.last),       2'(out_word.last));
                end
            end

            pending <= phase_q.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top: command stimulus, output back-pressure, timing register writes and verdict.
`timescale 1ns / 1ps

module tb_top;
    import i2cbb_pkg::*;

    // code the block must ignore
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // extra cycles after the last phase word; covers the pipeline latency and an
    // ignored command that may still be in the pipe
    localparam int SETTLE_CYCLES = 40;
    // receiver hold-off long enough for the block to fill and stall its input
    localparam int LONG_HOLD     = 300;
    // run limit: several times the slowest correct run (all writes, full stalls)
    localparam int CYCLE_LIMIT   = 400000;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    in_word_t    in_word   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_word_t   out_word;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = 3'd0;
    logic [31:0] pwdata    = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    int errors;
    int pending;

    // random idle bursts on both sides while set; cleared for the last part
    bit idle_on       = 1'b1;
    // one-shot request for the long receiver hold-off
    bit long_hold_req = 1'b0;

    i2c_bitbang_master_write_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    i2c_phase_checker phase_chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Present one command word and hold it until accepted. A random idle burst
    // may come first; valid is dropped only for that gap.
    task automatic send_cmd(input logic [1:0] code, input logic [7:0] data, input logic sda);
        int gap;
        in_word_t w;
        w.cmd        = code;
        w.tx_byte    = data;
        w.sensed_sda = sda;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // APB write: setup cycle, then access cycle until pready
    task automatic cfg_write(input logic idx, input logic [15:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'h0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // APB read; the checker compares prdata with its copy of the register
    task automatic cfg_read(input logic idx);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_timing(input logic [15:0] brief, input logic [15:0] lng);
        cfg_write(REG_BRIEF, brief);
        cfg_write(REG_LONG, lng);
        cfg_read(REG_BRIEF);
        cfg_read(REG_LONG);
    endtask

    // Sender stops and waits for every expected phase word. The first edge lets
    // the checker count the last accepted command before pending is trusted.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mostly well-formed transfers (start, 1..4 bytes, usually a stop, else the
    // next command follows without one) with random content; the rest is single random
    // commands, unused code included. Ignored words do not count.
    task automatic random_traffic(input int target);
        int sent;
        int nbytes;
        int k;
        logic [1:0] code;
        sent = 0;
        while (sent < target)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                send_cmd(CMD_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                sent++;
                nbytes = $urandom_range(1, 4);
                for (k = 0; k < nbytes; k++)
                begin
                    send_cmd(CMD_WRITE, 8'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)));
                    sent++;
                end
                if ($urandom_range(0, 5) != 0)
                begin
                    send_cmd(CMD_STOP, 8'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)));
                    sent++;
                end
            end
            else
            begin
                code = 2'($urandom_range(0, 3));
                send_cmd(code, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                if (code != CMD_UNUSED)
                    sent++;
            end
        end
    endtask

    // Receiver: random not-ready bursts, plus the long hold-off on request,
    // counted here in cycles.
    initial
    begin : phase_sink
        int hold_left;
        hold_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                out_ready <= 1'b0;
                hold_left = $urandom_range(1, 6) - 1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Watchdog: the run must finish well inside the limit
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin : stimulus
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values read back, then the extreme timing setting
        cfg_read(REG_BRIEF);
        cfg_read(REG_LONG);
        set_timing(16'hFFFF, 16'h0000);

        // Directed part. Straight out of reset: an unused code (no phases),
        // a stop with SCL still released, and a byte write with no start.
        send_cmd(CMD_UNUSED, 8'hFF, 1'b1);
        send_cmd(CMD_STOP,   8'h00, 1'b0);
        send_cmd(CMD_WRITE,  8'h00, 1'b1);
        // normal transfer; all-ones, MSB-only, LSB-only and alternating bytes,
        // with both ack and nack
        send_cmd(CMD_START,  8'h00, 1'b0);
        send_cmd(CMD_WRITE,  8'hFF, 1'b0);
        send_cmd(CMD_WRITE,  8'h80, 1'b1);
        send_cmd(CMD_WRITE,  8'h01, 1'b0);
        send_cmd(CMD_WRITE,  8'h55, 1'b1);
        send_cmd(CMD_WRITE,  8'hAA, 1'b0);
        send_cmd(CMD_STOP,   8'hFF, 1'b1);
        // back-to-back stops, repeated start, unused code mid transfer
        send_cmd(CMD_STOP,   8'h00, 1'b0);
        send_cmd(CMD_START,  8'hFF, 1'b1);
        send_cmd(CMD_START,  8'h00, 1'b0);
        send_cmd(CMD_WRITE,  8'h7E, 1'b1);
        send_cmd(CMD_UNUSED, 8'h00, 1'b0);
        send_cmd(CMD_WRITE,  8'hC3, 1'b0);
        send_cmd(CMD_STOP,   8'h00, 1'b0);
        // write right after a stop, then a stop again
        send_cmd(CMD_WRITE,  8'h3C, 1'b0);
        send_cmd(CMD_STOP,   8'h5A, 1'b1);
        wait_drained();

        // phase A: other extreme; the long receiver hold-off lands mid-way
        set_timing(16'h0000, 16'hFFFF);
        random_traffic(40);
        long_hold_req = 1'b1;
        random_traffic(80);
        wait_drained();

        // phase B: random timing values
        set_timing(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        random_traffic(110);
        wait_drained();

        // phase C: no idling on either side
        idle_on = 1'b0;
        set_timing(16'h0001, 16'h8000);
        random_traffic(60);
        wait_drained();

        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
